FILE: src/stok_pkg.sv
// Types, codes and the character classifier shared by the tokenizer modules.
package stok_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_INT,
    MODE_SYM,
    MODE_STR_DQ,
    MODE_STR_SQ,
    MODE_ESC_DQ,
    MODE_ESC_SQ
  } mode_t;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_LETTER,
    CLS_DIGIT,
    CLS_SYMBOL,
    CLS_EQUALS,
    CLS_DQUOTE,
    CLS_SQUOTE,
    CLS_BSLASH
  } cls_t;

  localparam logic [1:0] KIND_WORD = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_STR  = 2'd2;
  localparam logic [1:0] KIND_SYM  = 2'd3;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_EQUALS = 8'h3d;
  localparam logic [7:0] CH_NONE   = 8'h00;

  typedef struct packed {
    logic [7:0] ch;
    logic       text_start;
  } text_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       text_start;
    cls_t       cls;
  } class_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tok_char;
    logic       char_valid;
    logic       starts_token;
  } token_word_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r = CLS_OTHER;
    if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f) begin
      r = CLS_LETTER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = CLS_DIGIT;
    end else begin
      case (c)
        CH_EQUALS: r = CLS_EQUALS;
        CH_DQUOTE: r = CLS_DQUOTE;
        CH_SQUOTE: r = CLS_SQUOTE;
        CH_BSLASH: r = CLS_BSLASH;
        8'h3b, 8'h2c, 8'h2e, 8'h25, 8'h7b, 8'h7d, 8'h28, 8'h29,
        8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3e, 8'h3c: r = CLS_SYMBOL;
        default: r = CLS_OTHER;
      endcase
    end
    return r;
  endfunction

endpackage

FILE: src/stok_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface stok_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/stok_front.sv
// Front stage: accept text bytes, classify them and register the result.
module stok_front (
  input logic   clk,
  input logic   rst,
  stok_if.sink   text,
  stok_if.source cls_out
);
  import stok_pkg::*;

  logic        stage_valid;
  class_word_t stage;

  assign text.ready    = !stage_valid || cls_out.ready;
  assign cls_out.valid = stage_valid;
  assign cls_out.data  = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (text.ready) begin
      stage_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      stage.ch         <= text.data.ch;
      stage.text_start <= text.data.text_start;
      stage.cls        <= classify(text.data.ch);
    end
  end

endmodule

FILE: src/stok_queue.sv
// Short flop-based queue between the classifier and the scanner.
module stok_queue #(
  parameter int DEPTH = 4
) (
  input logic   clk,
  input logic   rst,
  stok_if.sink   wr,
  stok_if.source rd
);
  import stok_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  class_word_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr.ready = (count != CNT_W'(DEPTH));
  assign rd.valid = (count != '0);
  assign rd.data  = mem[rd_ptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr.data;
    end
  end

endmodule

FILE: src/stok_back.sv
// Back stage: run the scanning mode and register at most one token word per byte.
module stok_back (
  input logic   clk,
  input logic   rst,
  stok_if.sink   cls_in,
  stok_if.source token
);
  import stok_pkg::*;

  mode_t       mode;
  mode_t       mode_next;
  mode_t       eff;
  mode_t       idle_next;
  cls_t        cls;
  logic [7:0]  ch;
  logic        pop;
  logic        emit;
  logic        idle_emit;
  token_word_t res;
  token_word_t idle_res;
  logic        out_valid;
  token_word_t out_word;

  assign cls = cls_in.data.cls;
  assign ch  = cls_in.data.ch;
  assign eff = cls_in.data.text_start ? MODE_IDLE : mode;

  assign cls_in.ready = !out_valid || token.ready;
  assign pop          = cls_in.valid && cls_in.ready;
  assign token.valid  = out_valid;
  assign token.data   = out_word;

  always_comb begin
    unique case (cls)
      CLS_DQUOTE:             idle_next = MODE_STR_DQ;
      CLS_SQUOTE:             idle_next = MODE_STR_SQ;
      CLS_SYMBOL, CLS_EQUALS: idle_next = MODE_SYM;
      CLS_LETTER:             idle_next = MODE_WORD;
      CLS_DIGIT:              idle_next = MODE_INT;
      CLS_OTHER, CLS_BSLASH:  idle_next = MODE_IDLE;
    endcase
  end

  always_comb begin
    unique case (eff)
      MODE_IDLE:   mode_next = idle_next;
      MODE_WORD:   mode_next = (cls == CLS_LETTER || cls == CLS_DIGIT) ? MODE_WORD : idle_next;
      MODE_INT:    mode_next = (cls == CLS_DIGIT) ? MODE_INT : idle_next;
      MODE_SYM:    mode_next = (cls == CLS_EQUALS) ? MODE_IDLE : idle_next;
      MODE_STR_DQ: mode_next = (cls == CLS_DQUOTE) ? MODE_IDLE :
                               (cls == CLS_BSLASH) ? MODE_ESC_DQ : MODE_STR_DQ;
      MODE_STR_SQ: mode_next = (cls == CLS_SQUOTE) ? MODE_IDLE :
                               (cls == CLS_BSLASH) ? MODE_ESC_SQ : MODE_STR_SQ;
      MODE_ESC_DQ: mode_next = MODE_STR_DQ;
      MODE_ESC_SQ: mode_next = MODE_STR_SQ;
    endcase
  end

  always_comb begin
    idle_res.tok_char     = ch;
    idle_res.char_valid   = 1'b1;
    idle_res.starts_token = 1'b1;
    idle_emit             = 1'b1;
    unique case (cls)
      CLS_DQUOTE, CLS_SQUOTE: begin
        idle_res.kind       = KIND_STR;
        idle_res.tok_char   = CH_NONE;
        idle_res.char_valid = 1'b0;
      end
      CLS_SYMBOL, CLS_EQUALS: idle_res.kind = KIND_SYM;
      CLS_LETTER:             idle_res.kind = KIND_WORD;
      CLS_DIGIT:              idle_res.kind = KIND_INT;
      CLS_OTHER, CLS_BSLASH: begin
        idle_res.kind = KIND_WORD;
        idle_emit     = 1'b0;
      end
    endcase
  end

  always_comb begin
    res.tok_char     = ch;
    res.char_valid   = 1'b1;
    res.starts_token = 1'b0;
    res.kind         = KIND_STR;
    emit             = 1'b1;
    unique case (eff)
      MODE_IDLE: begin
        res  = idle_res;
        emit = idle_emit;
      end
      MODE_WORD: begin
        if (cls == CLS_LETTER || cls == CLS_DIGIT) begin
          res.kind = KIND_WORD;
        end else begin
          res  = idle_res;
          emit = idle_emit;
        end
      end
      MODE_INT: begin
        if (cls == CLS_DIGIT) begin
          res.kind = KIND_INT;
        end else begin
          res  = idle_res;
          emit = idle_emit;
        end
      end
      MODE_SYM: begin
        if (cls == CLS_EQUALS) begin
          res.kind = KIND_SYM;
        end else begin
          res  = idle_res;
          emit = idle_emit;
        end
      end
      MODE_STR_DQ:              emit = (cls != CLS_DQUOTE);
      MODE_STR_SQ:              emit = (cls != CLS_SQUOTE);
      MODE_ESC_DQ, MODE_ESC_SQ: emit = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      out_valid <= 1'b0;
    end else if (pop) begin
      mode      <= mode_next;
      out_valid <= emit;
    end else if (token.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_word <= res;
    end
  end

endmodule

FILE: src/source_tokenizer_unit.sv
// Source tokenizer top level: classifier, queue and scanner.
// Takes one text byte per cycle on text while nothing stalls and labels it with the token
// it belongs to on token, at most one word out per byte in. A byte is classified and
// registered in the front stage, waits in a QUEUE_DEPTH-entry queue and is scanned by the
// back stage, whose mode register advances once per byte and sets the rate of one byte
// per cycle; a result passes the front, queue and back registers. Skipped bytes
// and closing quotes give no word. text_start set on a byte drops any open token first.
module source_tokenizer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input logic   clk,
  input logic   rst,
  stok_if.sink   text,
  stok_if.source token
);
  import stok_pkg::*;

  stok_if #(.T(class_word_t)) front_q ();
  stok_if #(.T(class_word_t)) q_back ();

  stok_front u_front (
    .clk     (clk),
    .rst     (rst),
    .text    (text),
    .cls_out (front_q.source)
  );

  stok_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (front_q.sink),
    .rd  (q_back.source)
  );

  stok_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cls_in (q_back.sink),
    .token  (token)
  );

endmodule

FILE: src/stok_checker.sv
// Port-level checks on the tokenizer output, bound to the top level.
module stok_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   tok_valid,
  input logic                   tok_ready,
  input stok_pkg::token_word_t  tok_data
);
  import stok_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(tok_data))
    else $error("token word dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !tok_valid)
    else $error("token word shown straight after reset");

  a_marker: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_data.char_valid |->
      tok_data.kind == KIND_STR && tok_data.starts_token && tok_data.tok_char == CH_NONE)
    else $error("bad string opening marker");

  a_sym_join: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_data.kind == KIND_SYM && !tok_data.starts_token |->
      tok_data.tok_char == CH_EQUALS)
    else $error("symbol continued by a byte other than equals");

  a_word_start: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_data.kind == KIND_WORD && tok_data.starts_token |->
      tok_data.tok_char < 8'h30 || tok_data.tok_char > 8'h39)
    else $error("word started by a digit");

endmodule

bind source_tokenizer_unit stok_checker u_stok_checker (
  .clk       (clk),
  .rst       (rst),
  .tok_valid (token.valid),
  .tok_ready (token.ready),
  .tok_data  (token.data)
);

FILE: dv/stok_token_checker.sv
// Watches the text and token channels, predicts each token word and compares.
`timescale 1ns / 1ps

module stok_token_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  input  logic                  text_ready,
  input  stok_pkg::text_word_t  text_data,
  input  logic                  token_valid,
  input  logic                  token_ready,
  input  stok_pkg::token_word_t token_data,
  output int                    fail_count,
  output int                    pending
);
  import stok_pkg::*;

  mode_t       scan_mode = MODE_IDLE;
  token_word_t expected_tokens[$];
  int          fails = 0;
  int          outstanding = 0;

  assign fail_count = fails;
  assign pending    = outstanding;

  task automatic report(input string what);
    $display("%0t ns: token mismatch: %s", $time, what);
    fails++;
  endtask

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_symbol(input logic [7:0] c);
    case (c)
      ";", ",", ".", "%", "{", "}", "(", ")", "+", "-", "*", "/", ">", "<", "=": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic token_word_t make_token(input logic [1:0] kind, input logic [7:0] c,
                                             input logic valid, input logic start);
    token_word_t t;
    t.kind         = kind;
    t.tok_char     = c;
    t.char_valid   = valid;
    t.starts_token = start;
    return t;
  endfunction

  // Byte seen with no token open: may open one.
  function automatic bit open_token(input logic [7:0] c, output mode_t m,
                                    output token_word_t t);
    m = MODE_IDLE;
    t = make_token(KIND_WORD, CH_NONE, 1'b0, 1'b0);
    if (c == CH_DQUOTE) begin
      m = MODE_STR_DQ;
      t = make_token(KIND_STR, CH_NONE, 1'b0, 1'b1);
      return 1'b1;
    end
    if (c == CH_SQUOTE) begin
      m = MODE_STR_SQ;
      t = make_token(KIND_STR, CH_NONE, 1'b0, 1'b1);
      return 1'b1;
    end
    if (is_symbol(c)) begin
      m = MODE_SYM;
      t = make_token(KIND_SYM, c, 1'b1, 1'b1);
      return 1'b1;
    end
    if (is_letter(c)) begin
      m = MODE_WORD;
      t = make_token(KIND_WORD, c, 1'b1, 1'b1);
      return 1'b1;
    end
    if (is_digit(c)) begin
      m = MODE_INT;
      t = make_token(KIND_INT, c, 1'b1, 1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit scan_byte(input logic [7:0] c, input logic restart,
                                   inout mode_t m, output token_word_t t);
    logic [7:0] closer;
    if (restart) m = MODE_IDLE;
    t = make_token(KIND_WORD, CH_NONE, 1'b0, 1'b0);
    case (m)
      MODE_WORD: begin
        if (is_letter(c) || is_digit(c)) begin
          t = make_token(KIND_WORD, c, 1'b1, 1'b0);
          return 1'b1;
        end
      end
      MODE_INT: begin
        if (is_digit(c)) begin
          t = make_token(KIND_INT, c, 1'b1, 1'b0);
          return 1'b1;
        end
      end
      MODE_SYM: begin
        if (c == CH_EQUALS) begin
          m = MODE_IDLE;
          t = make_token(KIND_SYM, c, 1'b1, 1'b0);
          return 1'b1;
        end
      end
      MODE_STR_DQ, MODE_STR_SQ: begin
        closer = (m == MODE_STR_DQ) ? CH_DQUOTE : CH_SQUOTE;
        if (c == closer) begin
          m = MODE_IDLE;
          return 1'b0;
        end
        if (c == CH_BSLASH) m = (m == MODE_STR_DQ) ? MODE_ESC_DQ : MODE_ESC_SQ;
        t = make_token(KIND_STR, c, 1'b1, 1'b0);
        return 1'b1;
      end
      MODE_ESC_DQ: begin
        m = MODE_STR_DQ;
        t = make_token(KIND_STR, c, 1'b1, 1'b0);
        return 1'b1;
      end
      MODE_ESC_SQ: begin
        m = MODE_STR_SQ;
        t = make_token(KIND_STR, c, 1'b1, 1'b0);
        return 1'b1;
      end
      default: ;
    endcase
    return open_token(c, m, t);
  endfunction

  always @(posedge clk) begin : watch
    mode_t       next_mode;
    token_word_t predicted;
    token_word_t oldest;
    if (rst) begin
      scan_mode = MODE_IDLE;
      expected_tokens.delete();
    end else begin
      if (token_valid && token_ready) begin
        if (expected_tokens.size() == 0) begin
          report($sformatf("unexpected word kind %0d char %02h", token_data.kind,
                           token_data.tok_char));
        end else begin
          oldest = expected_tokens.pop_front();
          if (token_data.kind != oldest.kind)
            report($sformatf("kind %0d, predicted %0d", token_data.kind, oldest.kind));
          if (token_data.tok_char != oldest.tok_char)
            report($sformatf("tok_char %02h, predicted %02h", token_data.tok_char,
                             oldest.tok_char));
          if (token_data.char_valid != oldest.char_valid)
            report($sformatf("char_valid %0b, predicted %0b", token_data.char_valid,
                             oldest.char_valid));
          if (token_data.starts_token != oldest.starts_token)
            report($sformatf("starts_token %0b, predicted %0b", token_data.starts_token,
                             oldest.starts_token));
        end
      end
      if (text_valid && text_ready) begin
        next_mode = scan_mode;
        if (scan_byte(text_data.ch, text_data.text_start, next_mode, predicted))
          expected_tokens.insert(expected_tokens.size(), predicted);
        scan_mode = next_mode;
      end
    end
    outstanding = expected_tokens.size();
  end

endmodule

FILE: dv/tb_source_tokenizer_unit.sv
// Top of the source tokenizer testbench: clock, reset, text stimulus and verdict.
`timescale 1ns / 1ps

module tb_source_tokenizer_unit;
  import stok_pkg::*;

  localparam int RANDOM_BYTES = 1550;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [8*15-1:0] SYMBOL_SET = ";,.%{}()+-*/><=";

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   burst_left = 0;
  int   bytes_sent = 0;
  int   fail_count;
  int   pending;
  int   stall_style = 0;
  int   style_left = 0;
  int   hold_left = 0;
  logic hold_ready = 1'b0;

  stok_if #(.T(text_word_t))  text_ch();
  stok_if #(.T(token_word_t)) token_ch();

  source_tokenizer_unit u_dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_ch),
    .token (token_ch)
  );

  stok_token_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_ch.valid),
    .text_ready  (text_ch.ready),
    .text_data   (text_ch.data),
    .token_valid (token_ch.valid),
    .token_ready (token_ch.ready),
    .token_data  (token_ch.data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stalls: one of four styles, picked at random, drives token ready.
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(50, 300);
    end
    style_left--;
    case (stall_style)
      0: token_ch.ready <= 1'b1;
      1: token_ch.ready <= ($urandom_range(0, 3) != 0);
      2: token_ch.ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left == 0) begin
          hold_ready = !hold_ready;
          hold_left  = hold_ready ? $urandom_range(1, 8) : $urandom_range(1, 20);
        end
        hold_left--;
        token_ch.ready <= hold_ready;
      end
    endcase
  end

  function automatic logic [7:0] rand_letter();
    case ($urandom_range(0, 4))
      0, 1:    return "a" + 8'($urandom_range(0, 25));
      2, 3:    return "A" + 8'($urandom_range(0, 25));
      default: return "_";
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_symbol();
    return SYMBOL_SET[8*$urandom_range(0, 14) +: 8];
  endfunction

  // Send one byte; bursts of random length separated by random gaps.
  task automatic put_byte(input logic [7:0] c, input logic restart);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        text_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    text_ch.valid <= 1'b1;
    text_ch.data  <= text_word_t'{ch: c, text_start: restart};
    do @(posedge clk); while (!text_ch.ready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic put_random_token();
    int         pick;
    logic       restart;
    logic [7:0] closer;
    logic [7:0] other;
    logic [7:0] c;
    restart = ($urandom_range(0, 23) == 0);
    pick    = $urandom_range(0, 15);
    if (pick < 4) begin
      put_byte(rand_letter(), restart);
      repeat ($urandom_range(0, 7))
        put_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter(), 1'b0);
    end else if (pick < 6) begin
      put_byte(rand_digit(), restart);
      repeat ($urandom_range(0, 5)) put_byte(rand_digit(), 1'b0);
    end else if (pick < 9) begin
      closer = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
      other  = (closer == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE;
      put_byte(closer, restart);
      repeat ($urandom_range(0, 10)) begin
        c = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 5) == 0) begin
          put_byte(CH_BSLASH, 1'b0);
          put_byte($urandom_range(0, 1) ? closer : c, 1'b0);
        end else begin
          if ($urandom_range(0, 7) == 0) c = other;
          if (c == closer || c == CH_BSLASH) c = rand_letter();
          put_byte(c, 1'b0);
        end
      end
      if ($urandom_range(0, 7) != 0) put_byte(closer, 1'b0);
    end else if (pick < 12) begin
      put_byte(rand_symbol(), restart);
      if ($urandom_range(0, 2) == 0) put_byte(CH_EQUALS, 1'b0);
    end else if (pick < 14) begin
      put_byte($urandom_range(0, 1) ? " " : "\n", restart);
    end else begin
      put_byte(8'($urandom_range(0, 255)), restart);
    end
    if ($urandom_range(0, 1) == 0) put_byte(" ", 1'b0);
  endtask

  initial begin
    text_ch.valid = 1'b0;
    text_ch.data  = '0;
    token_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    put_byte("a", 1'b1);
    put_byte("_", 1'b0);
    put_byte("9", 1'b0);
    put_byte("Z", 1'b0);
    put_byte(";", 1'b0);
    put_byte("=", 1'b0);
    put_byte("=", 1'b0);
    put_byte("0", 1'b0);
    put_byte("7", 1'b0);
    put_byte("q", 1'b0);
    put_byte(8'hff, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(CH_DQUOTE, 1'b0);
    put_byte(CH_SQUOTE, 1'b0);
    put_byte(CH_BSLASH, 1'b0);
    put_byte(CH_DQUOTE, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(CH_DQUOTE, 1'b0);
    put_byte(CH_SQUOTE, 1'b0);
    put_byte(CH_SQUOTE, 1'b0);
    put_byte(CH_DQUOTE, 1'b0);
    put_byte(CH_BSLASH, 1'b0);
    put_byte(CH_BSLASH, 1'b0);
    put_byte("\n", 1'b1);
    put_byte(CH_DQUOTE, 1'b1);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) put_random_token();
    text_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/stok_pkg.sv
src/stok_if.sv
src/stok_front.sv
src/stok_queue.sv
src/stok_back.sv
src/source_tokenizer_unit.sv
src/stok_checker.sv
dv/stok_token_checker.sv
dv/tb_source_tokenizer_unit.sv
